// File: design/bitmap_cell_row_decoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap cell row decoder
// Concurrent checks clocked on clk_i, held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BITMAP_CELL_ROW_DECODER_MACROS_SVH
`define BITMAP_CELL_ROW_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// pre in one cycle implies post in the next
`define BCRD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bcrd: next-cycle check failed");

// pre implies post in the same cycle
`define BCRD_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("bcrd: same-cycle check failed");

`else

`define BCRD_ASSERT_NEXT(lbl, pre, post)
`define BCRD_ASSERT_SAME(lbl, pre, post)

`endif

`endif

// File: design/bcrd_pkg.sv
// ---------------------------------------------------------------------------
// bcrd_pkg
// Types, constants and the palette ROM of the bitmap cell row decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package bcrd_pkg;

  localparam int unsigned NumPixels = 8;
  localparam int unsigned NumCodes  = 4;
  localparam int unsigned PalIdxW   = 4;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CodeW     = 2;
  localparam int unsigned CfgIdxW   = 1;

  typedef logic [PalIdxW-1:0] pal_idx_t;
  typedef logic [RgbW-1:0]    rgb_t;
  typedef logic [CodeW-1:0]   code_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MULTICOLOR_MODE  = 1'b0,
    CFG_BACKGROUND_COLOR = 1'b1
  } cfg_idx_e;

  // palette index chosen by each pixel code, shared by all lanes
  typedef struct packed {
    pal_idx_t [NumCodes-1:0] idx;
  } sel_set_t;

  // gray levels
  localparam logic [7:0] GrayBlack = 8'd0;
  localparam logic [7:0] GrayWhite = 8'd255;
  localparam logic [7:0] GrayDark  = 8'd51;
  localparam logic [7:0] GrayMid   = 8'd119;
  localparam logic [7:0] GrayLight = 8'd187;

  // colored palette entries
  localparam rgb_t PalRed        = {8'd136, 8'd0,   8'd0};
  localparam rgb_t PalCyan       = {8'd170, 8'd255, 8'd238};
  localparam rgb_t PalPurple     = {8'd204, 8'd68,  8'd204};
  localparam rgb_t PalGreen      = {8'd0,   8'd204, 8'd85};
  localparam rgb_t PalBlue       = {8'd0,   8'd0,   8'd170};
  localparam rgb_t PalYellow     = {8'd238, 8'd238, 8'd119};
  localparam rgb_t PalOrange     = {8'd221, 8'd136, 8'd85};
  localparam rgb_t PalBrown      = {8'd102, 8'd68,  8'd0};
  localparam rgb_t PalLightRed   = {8'd255, 8'd119, 8'd119};
  localparam rgb_t PalLightGreen = {8'd170, 8'd255, 8'd102};
  localparam rgb_t PalLightBlue  = {8'd0,   8'd136, 8'd255};

  localparam pal_idx_t NibbleMask = 4'hf;

  function automatic rgb_t pal_lookup(input pal_idx_t idx);
    rgb_t rgb;
    unique case (idx)
      4'd0:    rgb = {GrayBlack, GrayBlack, GrayBlack};
      4'd1:    rgb = {GrayWhite, GrayWhite, GrayWhite};
      4'd2:    rgb = PalRed;
      4'd3:    rgb = PalCyan;
      4'd4:    rgb = PalPurple;
      4'd5:    rgb = PalGreen;
      4'd6:    rgb = PalBlue;
      4'd7:    rgb = PalYellow;
      4'd8:    rgb = PalOrange;
      4'd9:    rgb = PalBrown;
      4'd10:   rgb = PalLightRed;
      4'd11:   rgb = {GrayDark, GrayDark, GrayDark};
      4'd12:   rgb = {GrayMid, GrayMid, GrayMid};
      4'd13:   rgb = PalLightGreen;
      4'd14:   rgb = PalLightBlue;
      4'd15:   rgb = {GrayLight, GrayLight, GrayLight};
      default: rgb = '0;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

// File: design/bcrd_lane.sv
// ---------------------------------------------------------------------------
// bcrd_lane
// One pixel lane: maps a pixel code to a palette index and looks up its RGB.
// ---------------------------------------------------------------------------
`default_nettype none

module bcrd_lane (
  input  var bcrd_pkg::sel_set_t sel_i,
  input  var bcrd_pkg::code_t    code_i,
  output bcrd_pkg::rgb_t         rgb_o
);

  bcrd_pkg::pal_idx_t idx;

  always_comb begin
    idx   = sel_i.idx[code_i] & bcrd_pkg::NibbleMask;
    rgb_o = bcrd_pkg::pal_lookup(idx);
  end

endmodule

`default_nettype wire

// File: design/bcrd_merge.sv
// ---------------------------------------------------------------------------
// bcrd_merge
// Collects the eight lane colors into the output row register and strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module bcrd_merge (
  input  var logic                                   clk_i,
  input  var logic                                   rst_ni,
  input  var logic                                   accept_i,
  input  var bcrd_pkg::rgb_t [bcrd_pkg::NumPixels-1:0] lane_rgb_i,
  output logic                                       done_o,
  output bcrd_pkg::rgb_t [bcrd_pkg::NumPixels-1:0]   row_rgb_o
);

  logic                                     done_q;
  bcrd_pkg::rgb_t [bcrd_pkg::NumPixels-1:0] row_d, row_q;

  always_comb begin
    row_d = row_q;
    if (accept_i) begin
      row_d = lane_rgb_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign done_o    = done_q;
  assign row_rgb_o = row_q;

endmodule

`default_nettype wire

// File: design/bitmap_cell_row_decoder.sv
// ---------------------------------------------------------------------------
// bitmap_cell_row_decoder
// One cell bitmap row in, eight palette RGB pixels out.
// ---------------------------------------------------------------------------
// A transaction is taken whenever start_i is high; busy_o stays low, so a new
// row can enter every cycle. The eight pixels of a row appear in the cycle after
// it is taken, with done_o high for exactly that cycle; there is no way to
// stall them, so the receiver must capture them then. Latency is the single
// output register behind eight parallel palette lanes. Configuration writes
// are always ready and belong in idle periods only.
`default_nettype none

`include "bitmap_cell_row_decoder_macros.svh"

module bitmap_cell_row_decoder (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  input  var logic                              start_i,
  output logic                                  busy_o,
  input  var logic [bcrd_pkg::ByteW-1:0]        bitmap_byte_i,
  input  var logic [bcrd_pkg::ByteW-1:0]        screen_byte_i,
  input  var logic [bcrd_pkg::ByteW-1:0]        color_byte_i,
  input  var logic                              cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  var logic [bcrd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  var logic [bcrd_pkg::PalIdxW-1:0]      cfg_data_i,
  output logic                                  done_o,
  output bcrd_pkg::rgb_t                        pixel0_rgb_o,
  output bcrd_pkg::rgb_t                        pixel1_rgb_o,
  output bcrd_pkg::rgb_t                        pixel2_rgb_o,
  output bcrd_pkg::rgb_t                        pixel3_rgb_o,
  output bcrd_pkg::rgb_t                        pixel4_rgb_o,
  output bcrd_pkg::rgb_t                        pixel5_rgb_o,
  output bcrd_pkg::rgb_t                        pixel6_rgb_o,
  output bcrd_pkg::rgb_t                        pixel7_rgb_o
);

  logic                 mode_d, mode_q;
  bcrd_pkg::pal_idx_t   bg_d, bg_q;
  logic                 accept;
  logic                 cfg_write;
  bcrd_pkg::sel_set_t   sel;

  bcrd_pkg::code_t [bcrd_pkg::NumPixels-1:0] code;
  bcrd_pkg::rgb_t  [bcrd_pkg::NumPixels-1:0] lane_rgb;
  bcrd_pkg::rgb_t  [bcrd_pkg::NumPixels-1:0] row_rgb;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_comb begin
    mode_d = mode_q;
    bg_d   = bg_q;
    if (cfg_write) begin
      unique case (bcrd_pkg::cfg_idx_e'(cfg_index_i))
        bcrd_pkg::CFG_MULTICOLOR_MODE:  mode_d = cfg_data_i[0];
        bcrd_pkg::CFG_BACKGROUND_COLOR: bg_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      bg_q   <= '0;
    end else begin
      mode_q <= mode_d;
      bg_q   <= bg_d;
    end
  end

  // palette index per code; hires only ever uses codes 0 and 1
  always_comb begin
    if (mode_q) begin
      sel.idx[0] = bg_q;
      sel.idx[1] = screen_byte_i[7:4];
      sel.idx[2] = screen_byte_i[3:0];
      sel.idx[3] = color_byte_i[3:0];
    end else begin
      sel.idx[0] = screen_byte_i[3:0];
      sel.idx[1] = screen_byte_i[7:4];
      sel.idx[2] = '0;
      sel.idx[3] = '0;
    end
  end

  // per-pixel codes: bit 7 is leftmost; multicolor pairs are double-wide
  for (genvar k = 0; k < bcrd_pkg::NumPixels; k++) begin : g_lane
    localparam int unsigned BitPos  = bcrd_pkg::NumPixels - 1 - k;
    localparam int unsigned PairPos = bcrd_pkg::NumPixels - 1 - 2 * (k / 2);

    always_comb begin
      if (mode_q) begin
        code[k] = bitmap_byte_i[PairPos -: 2];
      end else begin
        code[k] = {1'b0, bitmap_byte_i[BitPos]};
      end
    end

    bcrd_lane u_lane (
      .sel_i  (sel),
      .code_i (code[k]),
      .rgb_o  (lane_rgb[k])
    );
  end

  bcrd_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .lane_rgb_i (lane_rgb),
    .done_o     (done_o),
    .row_rgb_o  (row_rgb)
  );

  assign pixel0_rgb_o = row_rgb[0];
  assign pixel1_rgb_o = row_rgb[1];
  assign pixel2_rgb_o = row_rgb[2];
  assign pixel3_rgb_o = row_rgb[3];
  assign pixel4_rgb_o = row_rgb[4];
  assign pixel5_rgb_o = row_rgb[5];
  assign pixel6_rgb_o = row_rgb[6];
  assign pixel7_rgb_o = row_rgb[7];

  `BCRD_ASSERT_NEXT(a_done_follows_accept, accept, done_o)
  `BCRD_ASSERT_NEXT(a_no_spurious_done, !accept, !done_o)
  `BCRD_ASSERT_NEXT(a_blank_uniform, accept && bitmap_byte_i == '0, pixel0_rgb_o == pixel7_rgb_o)

endmodule

`default_nettype wire
